// ----- sv/ohrb_pkg.sv -----
// Shared constants, codes and types for the overwriting history ring buffer.
package ohrb_pkg;

  // Parameter defaults
  localparam int unsigned DEPTH_DEFAULT   = 1024;
  localparam int unsigned MAX_RUN_DEFAULT = 16;

  // Fixed field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 48;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 11;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_OK      = 2'd1,
    ST_BEYOND  = 2'd2,
    ST_CLAMPED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_BEYOND,
    BK_PREP,
    BK_INDEX,
    BK_STREAM
  } back_state_e;

  // Classified command as it sits in the queue
  typedef struct packed {
    cmd_e                op;
    logic [BYTE_W-1:0]   wr_byte;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;   // already limited to 1..MAX_RUN
  } entry_t;

endpackage

// ----- sv/ohrb_if.sv -----
// Valid/ready channel interfaces for command beats and result beats.
interface ohrb_in_if;
  logic                          valid;
  logic                          ready;
  logic [ohrb_pkg::CMD_W-1:0]    command;
  logic [ohrb_pkg::BYTE_W-1:0]   write_byte;
  logic [ohrb_pkg::OFFSET_W-1:0] read_offset;
  logic [ohrb_pkg::COUNT_W-1:0]  read_count;

  modport source (output valid, command, write_byte, read_offset, read_count, input ready);
  modport sink   (input valid, command, write_byte, read_offset, read_count, output ready);
endinterface

interface ohrb_out_if;
  logic                          valid;
  logic                          ready;
  logic [ohrb_pkg::BYTE_W-1:0]   read_byte;
  logic [ohrb_pkg::STATUS_W-1:0] status;
  logic [ohrb_pkg::OFFSET_W-1:0] byte_offset;
  logic                          last;
  logic [ohrb_pkg::OFFSET_W-1:0] total_written;
  logic [ohrb_pkg::FILL_W-1:0]   fill_level;
  logic [ohrb_pkg::OFFSET_W-1:0] oldest_offset;

  modport source (output valid, read_byte, status, byte_offset, last, total_written,
                  fill_level, oldest_offset, input ready);
  modport sink   (input valid, read_byte, status, byte_offset, last, total_written,
                  fill_level, oldest_offset, output ready);
endinterface

// ----- sv/overwriting_history_ring_buffer.sv -----
// Top level of the overwriting history ring buffer.
//
//   channel   dir   handshake     beat contents
//   in_i      in    valid/ready   command, write_byte, read_offset, read_count
//   out_o     out   valid/ready   read_byte, status, byte_offset, last,
//                                 total_written, fill_level, oldest_offset
//
// Write and clear: handled in the back end from idle, result in the output register.
// Read: dequeue, then setup states CHECK (range check with clamp), PREP (distance) and
// INDEX (ring index), then one byte per cycle from the registered memory read port while
// the output is free, up to MAX_RUN bytes. An offset past the end loads its beat from BEYOND.
// A two-entry command queue lets the front keep taking beats while the back works.
// Reset clears control and ring state at once; memory contents are not cleared.
// A stalled output holds its beat and stops the back end; the queue then fills.
module overwriting_history_ring_buffer #(
  parameter int unsigned DEPTH   = ohrb_pkg::DEPTH_DEFAULT,
  parameter int unsigned MAX_RUN = ohrb_pkg::MAX_RUN_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ohrb_in_if.sink    in_i,
  ohrb_out_if.source out_o
);

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  ohrb_pkg::entry_t push_entry, pop_entry;

  ohrb_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  ohrb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  ohrb_back #(
    .DEPTH   (DEPTH),
    .MAX_RUN (MAX_RUN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

// ----- sv/ohrb_front.sv -----
// Front end: accepts command beats, drops unknown codes, limits the run length.
module ohrb_front #(
  parameter int unsigned MAX_RUN = ohrb_pkg::MAX_RUN_DEFAULT
) (
  ohrb_in_if.sink          in_i,
  output logic             push_valid_o,
  output ohrb_pkg::entry_t push_entry_o,
  input  logic             push_ready_i
);

  logic                          known;
  logic [ohrb_pkg::COUNT_W-1:0]  count_lim;

  // Decode the command code
  always_comb begin
    case (ohrb_pkg::cmd_e'(in_i.command))
      ohrb_pkg::CMD_WRITE: known = 1'b1;
      ohrb_pkg::CMD_READ:  known = 1'b1;
      ohrb_pkg::CMD_CLEAR: known = 1'b1;
      default:             known = 1'b0;
    endcase
  end

  // Zero count reads as one, large counts saturate at MAX_RUN
  always_comb begin
    if (in_i.read_count == '0) begin
      count_lim = ohrb_pkg::COUNT_W'(1);
    end else if (32'(in_i.read_count) > MAX_RUN) begin
      count_lim = ohrb_pkg::COUNT_W'(MAX_RUN);
    end else begin
      count_lim = in_i.read_count;
    end
  end

  assign push_entry_o.op      = ohrb_pkg::cmd_e'(in_i.command);
  assign push_entry_o.wr_byte = in_i.write_byte;
  assign push_entry_o.offset  = in_i.read_offset;
  assign push_entry_o.count   = count_lim;

  // Unknown commands are taken and discarded
  assign push_valid_o = in_i.valid && known;
  assign in_i.ready   = known ? push_ready_i : 1'b1;

endmodule

// ----- sv/ohrb_queue.sv -----
// Short FIFO of classified commands between front and back.
module ohrb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  ohrb_pkg::entry_t push_entry_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output ohrb_pkg::entry_t pop_entry_o,
  input  logic             pop_ready_i
);

  localparam int unsigned PTR_W = (ohrb_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(ohrb_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(ohrb_pkg::QUEUE_DEPTH + 1);

  ohrb_pkg::entry_t slot_q [ohrb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(ohrb_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign push_ready_o = (count_q != CNT_W'(ohrb_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- sv/ohrb_back.sv -----
// Back end: ring state, byte memory and result sequencer with output register.
module ohrb_back #(
  parameter int unsigned DEPTH   = ohrb_pkg::DEPTH_DEFAULT,
  parameter int unsigned MAX_RUN = ohrb_pkg::MAX_RUN_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  ohrb_pkg::entry_t pop_entry_i,
  output logic             pop_ready_o,
  ohrb_out_if.source       out_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned RUN_W = $clog2(MAX_RUN + 1);
  localparam int unsigned OW    = ohrb_pkg::OFFSET_W;
  localparam logic [AW:0] DEPTH_EXT = (AW + 1)'(DEPTH);

  // Ring state
  ohrb_pkg::back_state_e state_q, state_d;
  logic [OW-1:0]    total_q, total_d;
  logic [OW-1:0]    oldest_q, oldest_d;
  logic [CW-1:0]    held_q, held_d;
  logic [AW-1:0]    start_q, start_d;
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;

  // Read run working registers
  logic [OW-1:0]    off_q, off_d;
  logic [RUN_W-1:0] cnt_q, cnt_d;
  logic             clamp_q, clamp_d;
  logic [OW-1:0]    avail_q, avail_d;
  logic [AW-1:0]    delta_q, delta_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [RUN_W-1:0] remain_q, remain_d;

  // Memory
  logic [ohrb_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [ohrb_pkg::BYTE_W-1:0] rdata_q;
  logic                        mem_we, mem_re;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic                      out_zero_q, out_zero_d;
  ohrb_pkg::status_e         out_status_q, out_status_d;
  logic [OW-1:0]             out_offset_q, out_offset_d;
  logic                      out_last_q, out_last_d;
  logic [OW-1:0]             out_total_q, out_total_d;
  logic [CW-1:0]             out_fill_q, out_fill_d;
  logic [OW-1:0]             out_oldest_q, out_oldest_d;
  logic                      out_load, out_free;

  logic                      full;
  logic [OW-1:0]             diff;
  logic [AW:0]               idx_sum;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  assign full     = (held_q == CW'(DEPTH));
  assign out_free = !out_valid_q || out_o.ready;
  assign diff     = off_q - oldest_q;
  assign idx_sum  = {1'b0, start_q} + {1'b0, delta_q};

  // Sequencer: next state, ring update and result loading
  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    oldest_d     = oldest_q;
    held_d       = held_q;
    start_d      = start_q;
    wr_ptr_d     = wr_ptr_q;
    off_d        = off_q;
    cnt_d        = cnt_q;
    clamp_d      = clamp_q;
    avail_d      = avail_q;
    delta_d      = delta_q;
    idx_d        = idx_q;
    remain_d     = remain_q;
    pop_ready_o  = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    out_load     = 1'b0;
    out_zero_d   = out_zero_q;
    out_status_d = out_status_q;
    out_offset_d = out_offset_q;
    out_last_d   = out_last_q;
    out_total_d  = out_total_q;
    out_fill_d   = out_fill_q;
    out_oldest_d = out_oldest_q;

    case (state_q)
      ohrb_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          case (pop_entry_i.op)
            ohrb_pkg::CMD_WRITE: begin
              if (out_free) begin
                pop_ready_o = 1'b1;
                mem_we      = 1'b1;
                wr_ptr_d    = ring_next(wr_ptr_q);
                total_d     = total_q + OW'(1);
                if (full) begin
                  start_d  = ring_next(start_q);
                  oldest_d = oldest_q + OW'(1);
                end else begin
                  held_d = held_q + CW'(1);
                end
                out_load     = 1'b1;
                out_zero_d   = 1'b1;
                out_status_d = ohrb_pkg::ST_DONE;
                out_offset_d = total_q;
                out_last_d   = 1'b1;
                out_total_d  = total_d;
                out_fill_d   = held_d;
                out_oldest_d = oldest_d;
              end
            end
            ohrb_pkg::CMD_CLEAR: begin
              if (out_free) begin
                pop_ready_o  = 1'b1;
                total_d      = '0;
                oldest_d     = '0;
                held_d       = '0;
                start_d      = '0;
                wr_ptr_d     = '0;
                out_load     = 1'b1;
                out_zero_d   = 1'b1;
                out_status_d = ohrb_pkg::ST_DONE;
                out_offset_d = '0;
                out_last_d   = 1'b1;
                out_total_d  = '0;
                out_fill_d   = '0;
                out_oldest_d = '0;
              end
            end
            ohrb_pkg::CMD_READ: begin
              pop_ready_o = 1'b1;
              off_d       = pop_entry_i.offset;
              cnt_d       = RUN_W'(pop_entry_i.count);
              state_d     = ohrb_pkg::BK_CHECK;
            end
            default: begin
              pop_ready_o = 1'b1;
            end
          endcase
        end
      end

      // Past the end, or clamp up to the oldest held byte
      ohrb_pkg::BK_CHECK: begin
        if (off_q >= total_q) begin
          state_d = ohrb_pkg::BK_BEYOND;
        end else begin
          clamp_d = (off_q < oldest_q);
          off_d   = (off_q < oldest_q) ? oldest_q : off_q;
          state_d = ohrb_pkg::BK_PREP;
        end
      end

      ohrb_pkg::BK_BEYOND: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_zero_d   = 1'b1;
          out_status_d = ohrb_pkg::ST_BEYOND;
          out_offset_d = off_q;
          out_last_d   = 1'b1;
          out_total_d  = total_q;
          out_fill_d   = held_q;
          out_oldest_d = oldest_q;
          state_d      = ohrb_pkg::BK_IDLE;
        end
      end

      // Bytes left to the end, distance from the oldest byte
      ohrb_pkg::BK_PREP: begin
        avail_d = total_q - off_q;
        delta_d = diff[AW-1:0];
        state_d = ohrb_pkg::BK_INDEX;
      end

      // Run length and first ring position
      ohrb_pkg::BK_INDEX: begin
        remain_d = (avail_q < OW'(cnt_q)) ? avail_q[RUN_W-1:0] : cnt_q;
        idx_d    = (idx_sum >= DEPTH_EXT) ? AW'(idx_sum - DEPTH_EXT) : idx_sum[AW-1:0];
        state_d  = ohrb_pkg::BK_STREAM;
      end

      // One byte per beat while the output side takes them
      ohrb_pkg::BK_STREAM: begin
        if (out_free) begin
          mem_re       = 1'b1;
          out_load     = 1'b1;
          out_zero_d   = 1'b0;
          out_status_d = clamp_q ? ohrb_pkg::ST_CLAMPED : ohrb_pkg::ST_OK;
          out_offset_d = off_q;
          out_last_d   = (remain_q == RUN_W'(1));
          out_total_d  = total_q;
          out_fill_d   = held_q;
          out_oldest_d = oldest_q;
          off_d        = off_q + OW'(1);
          idx_d        = ring_next(idx_q);
          remain_d     = remain_q - RUN_W'(1);
          if (remain_q == RUN_W'(1)) begin
            state_d = ohrb_pkg::BK_IDLE;
          end
        end
      end

      default: begin
        state_d = ohrb_pkg::BK_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ohrb_pkg::BK_IDLE;
      total_q     <= '0;
      oldest_q    <= '0;
      held_q      <= '0;
      start_q     <= '0;
      wr_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      oldest_q    <= oldest_d;
      held_q      <= held_d;
      start_q     <= start_d;
      wr_ptr_q    <= wr_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk_i) begin
    off_q        <= off_d;
    cnt_q        <= cnt_d;
    clamp_q      <= clamp_d;
    avail_q      <= avail_d;
    delta_q      <= delta_d;
    idx_q        <= idx_d;
    remain_q     <= remain_d;
    out_zero_q   <= out_zero_d;
    out_status_q <= out_status_d;
    out_offset_q <= out_offset_d;
    out_last_q   <= out_last_d;
    out_total_q  <= out_total_d;
    out_fill_q   <= out_fill_d;
    out_oldest_q <= out_oldest_d;
  end

  // Byte memory, registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= pop_entry_i.wr_byte;
    end
    if (mem_re) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_byte     = out_zero_q ? '0 : rdata_q;
  assign out_o.status        = out_status_q;
  assign out_o.byte_offset   = out_offset_q;
  assign out_o.last          = out_last_q;
  assign out_o.total_written = out_total_q;
  assign out_o.fill_level    = ohrb_pkg::FILL_W'(out_fill_q);
  assign out_o.oldest_offset = out_oldest_q;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the overwriting history ring buffer top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ohrb_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEFAULT;
  localparam int RUN_MAX    = MAX_RUN_DEFAULT;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 24;
  localparam int SHOW_MAX   = 10;
  localparam int PHASE_CMDS = 35;

  // Command code the block has to ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [BYTE_W-1:0]   wbyte;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
  } cmd_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   rbyte;
    status_e             status;
    logic [OFFSET_W-1:0] boff;
    logic                last;
    logic [OFFSET_W-1:0] total;
    logic [FILL_W-1:0]   fill;
    logic [OFFSET_W-1:0] oldest;
  } result_t;

  // One directed row; the typed columns hold a single known result
  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [BYTE_W-1:0]   wbyte;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
    bit                  typed;
    status_e             st;
    logic [OFFSET_W-1:0] boff;
    logic [OFFSET_W-1:0] total;
    logic [FILL_W-1:0]   fill;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [20] = '{
    '{CMD_READ,   8'h00, 48'h0,              5'd1,  1'b1, ST_BEYOND, 48'h0, 48'd0, 11'd0},
    '{CMD_READ,   8'h00, 48'hFFFF_FFFF_FFFF, 5'd31, 1'b1, ST_BEYOND, 48'hFFFF_FFFF_FFFF,
      48'd0, 11'd0},
    '{CMD_WRITE,  8'h00, 48'h0,              5'd0,  1'b1, ST_DONE,   48'd0, 48'd1, 11'd1},
    '{CMD_WRITE,  8'hFF, 48'h0,              5'd0,  1'b1, ST_DONE,   48'd1, 48'd2, 11'd2},
    '{CMD_WRITE,  8'hA5, 48'h0,              5'd0,  1'b1, ST_DONE,   48'd2, 48'd3, 11'd3},
    '{CMD_WRITE,  8'h5A, 48'h0,              5'd0,  1'b1, ST_DONE,   48'd3, 48'd4, 11'd4},
    '{CMD_READ,   8'h00, 48'd0,              5'd0,  1'b0, ST_DONE,   48'd0, 48'd0, 11'd0},
    '{CMD_READ,   8'h00, 48'd0,              5'd16, 1'b0, ST_DONE,   48'd0, 48'd0, 11'd0},
    '{CMD_READ,   8'h00, 48'd1,              5'd2,  1'b0, ST_DONE,   48'd0, 48'd0, 11'd0},
    '{CMD_READ,   8'h00, 48'd3,              5'd31, 1'b0, ST_DONE,   48'd0, 48'd0, 11'd0},
    '{CMD_READ,   8'h00, 48'd4,              5'd1,  1'b1, ST_BEYOND, 48'd4, 48'd4, 11'd4},
    '{CMD_READ,   8'h00, 48'd5,              5'd16, 1'b1, ST_BEYOND, 48'd5, 48'd4, 11'd4},
    '{CMD_UNUSED, 8'hFF, 48'hFFFF_FFFF_FFFF, 5'd31, 1'b0, ST_DONE,   48'd0, 48'd0, 11'd0},
    '{CMD_WRITE,  8'h3C, 48'h0,              5'd0,  1'b1, ST_DONE,   48'd4, 48'd5, 11'd5},
    '{CMD_CLEAR,  8'h00, 48'h0,              5'd0,  1'b1, ST_DONE,   48'd0, 48'd0, 11'd0},
    '{CMD_READ,   8'h00, 48'd0,              5'd1,  1'b1, ST_BEYOND, 48'd0, 48'd0, 11'd0},
    '{CMD_WRITE,  8'h81, 48'h0,              5'd0,  1'b1, ST_DONE,   48'd0, 48'd1, 11'd1},
    '{CMD_READ,   8'h00, 48'd0,              5'd17, 1'b0, ST_DONE,   48'd0, 48'd0, 11'd0},
    '{CMD_WRITE,  8'h7E, 48'h0,              5'd0,  1'b0, ST_DONE,   48'd0, 48'd0, 11'd0},
    '{CMD_READ,   8'h00, 48'd0,              5'd8,  1'b0, ST_DONE,   48'd0, 48'd0, 11'd0}
  };

  logic clk_i;
  logic rst_ni;

  ohrb_in_if  in_if ();
  ohrb_out_if out_if ();

  overwriting_history_ring_buffer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Own copy of the history ring
  logic [BYTE_W-1:0]   hist_mem [RING_DEPTH];
  logic [IDX_W-1:0]    hist_start;
  logic [FILL_W-1:0]   hist_fill;
  logic [OFFSET_W-1:0] hist_total;

  result_t due_beats [$];
  int      fault_count;
  int      idle_cycles;
  int      send_idle_pct;
  int      stall_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic string fmt_beat(result_t r);
    return $sformatf("byte=%02h st=%0d off=%0h last=%0b total=%0h fill=%0d oldest=%0h",
                     r.rbyte, r.status, r.boff, r.last, r.total, r.fill, r.oldest);
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= SHOW_MAX) $display("%0t: %s", $realtime, msg);
  endfunction

  // Result beat carrying the ring state after the command
  function automatic result_t ring_beat(logic [BYTE_W-1:0] b, status_e st,
                                        logic [OFFSET_W-1:0] off, logic lst);
    result_t r;
    r.rbyte  = b;
    r.status = st;
    r.boff   = off;
    r.last   = lst;
    r.total  = hist_total;
    r.fill   = hist_fill;
    r.oldest = hist_total - OFFSET_W'(hist_fill);
    return r;
  endfunction

  // Apply one command to the ring copy and list the beats it yields
  function automatic void history_step(input cmd_beat_t c, output result_t res[$]);
    logic [OFFSET_W-1:0] off;
    logic [OFFSET_W-1:0] oldest;
    logic [OFFSET_W-1:0] avail;
    int                  cnt;
    int                  n;
    int                  idx;
    status_e             st;
    res = {};
    oldest = hist_total - OFFSET_W'(hist_fill);
    if (c.command == CMD_WRITE) begin
      hist_mem[(int'(hist_start) + int'(hist_fill)) % RING_DEPTH] = c.wbyte;
      off = hist_total;
      if (hist_fill >= FILL_W'(RING_DEPTH)) begin
        hist_fill  = FILL_W'(RING_DEPTH);
        hist_start = IDX_W'((int'(hist_start) + 1) % RING_DEPTH);
      end else begin
        hist_fill++;
      end
      hist_total++;
      res.push_back(ring_beat(8'h00, ST_DONE, off, 1'b1));
    end else if (c.command == CMD_CLEAR) begin
      hist_start = '0;
      hist_fill  = '0;
      hist_total = '0;
      res.push_back(ring_beat(8'h00, ST_DONE, '0, 1'b1));
    end else if (c.command == CMD_READ) begin
      cnt = (c.count == '0) ? 1 : int'(c.count);
      if (cnt > RUN_MAX) cnt = RUN_MAX;
      off = c.offset;
      if (off >= hist_total) begin
        res.push_back(ring_beat(8'h00, ST_BEYOND, off, 1'b1));
      end else begin
        st = ST_OK;
        // overwritten history: start at the oldest byte still held
        if (off < oldest) begin
          off = oldest;
          st  = ST_CLAMPED;
        end
        avail = hist_total - off;
        n   = (OFFSET_W'(cnt) < avail) ? cnt : int'(avail);
        idx = (int'(hist_start) + int'(off - oldest)) % RING_DEPTH;
        for (int k = 0; k < n; k++) begin
          res.push_back(ring_beat(hist_mem[idx], st, off + OFFSET_W'(k), k == n - 1));
          idx = (idx + 1) % RING_DEPTH;
        end
      end
    end
  endfunction

  // Send one command beat, then record what it should produce
  task automatic issue_cmd(input cmd_beat_t c, input bit typed, input result_t typed_beat);
    int      gap;
    result_t res [$];
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= c.command;
    in_if.write_byte  <= c.wbyte;
    in_if.read_offset <= c.offset;
    in_if.read_count  <= c.count;
    do @(posedge clk_i); while (!in_if.ready);
    history_step(c, res);
    if (typed) due_beats.push_back(typed_beat);
    else foreach (res[i]) due_beats.push_back(res[i]);
  endtask

  // Hold the sender off until every outstanding beat is back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_beats.size() != 0);
  endtask

  // Result side: compare accepted beats, then pick next ready
  always @(posedge clk_i) begin
    result_t got;
    result_t exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.rbyte  = out_if.read_byte;
      got.status = status_e'(out_if.status);
      got.boff   = out_if.byte_offset;
      got.last   = out_if.last;
      got.total  = out_if.total_written;
      got.fill   = out_if.fill_level;
      got.oldest = out_if.oldest_offset;
      if (due_beats.size() == 0) begin
        note_fault({"unexpected result beat: ", fmt_beat(got)});
      end else begin
        exp = due_beats.pop_front();
        if (got.rbyte !== exp.rbyte || got.status !== exp.status || got.boff !== exp.boff ||
            got.last !== exp.last || got.total !== exp.total || got.fill !== exp.fill ||
            got.oldest !== exp.oldest)
          note_fault({"mismatch\n  expected: ", fmt_beat(exp), "\n  actual:   ", fmt_beat(got)});
      end
    end
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles without any beat moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    stim_row_t           row;
    cmd_beat_t           c;
    result_t             tb_beat;
    logic [OFFSET_W-1:0] oldest;
    int                  pick;
    int                  k;
    int                  issued;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.command     = CMD_WRITE;
    in_if.write_byte  = '0;
    in_if.read_offset = '0;
    in_if.read_count  = '0;
    out_if.ready      = 1'b0;
    hist_start        = '0;
    hist_fill         = '0;
    hist_total        = '0;
    fault_count       = 0;
    idle_cycles       = 0;
    send_idle_pct     = 0;
    stall_pct         = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DIRECTED_ROWS[i]) begin
      row     = DIRECTED_ROWS[i];
      c       = '{row.command, row.wbyte, row.offset, row.count};
      tb_beat = '{8'h00, row.st, row.boff, 1'b1, row.total, row.fill,
                  row.total - OFFSET_W'(row.fill)};
      issue_cmd(c, row.typed, tb_beat);
    end
    drain_results();

    // Random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 52; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase

      issued = 0;
      while (issued < PHASE_CMDS) begin
        c.offset = {$urandom(), $urandom()};
        c.count  = 5'($urandom_range(16, 1));
        c.wbyte  = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 48) begin
          c.command = CMD_WRITE;
        end else if (pick < 94) begin
          c.command = CMD_READ;
        end else if (pick < 96) begin
          c.command = CMD_CLEAR;
        end else begin
          c.command = CMD_UNUSED;
        end

        if (c.command == CMD_READ) begin
          oldest = hist_total - OFFSET_W'(hist_fill);
          pick = $urandom_range(99);
          if (pick < 40) begin
            if (hist_fill != '0)
              c.offset = oldest + OFFSET_W'($urandom_range(int'(hist_fill) - 1));
          end else if (pick < 55) begin
            k = $urandom_range(4, 1);
            if (OFFSET_W'(k) <= hist_total) c.offset = hist_total - OFFSET_W'(k);
          end else if (pick < 70) begin
            if (oldest != '0) c.offset = OFFSET_W'($urandom_range(32'(oldest) - 1));
          end else if (pick < 80) begin
            c.offset = hist_total + OFFSET_W'($urandom_range(2));
          end
          pick = $urandom_range(99);
          if (pick < 10) c.count = '0;
          else if (pick < 20) c.count = 5'($urandom_range(31, RUN_MAX + 1));
        end

        issue_cmd(c, 1'b0, '0);
        if (c.command != CMD_UNUSED) issued++;
        if ($urandom_range(99) < 3) drain_results();
      end
      drain_results();
    end

    // Let any late beat show up
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (due_beats.size() != 0)
      note_fault($sformatf("%0d expected result beats never arrived", due_beats.size()));
    if (fault_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ohrb_pkg.sv
sv/ohrb_if.sv
sv/ohrb_front.sv
sv/ohrb_queue.sv
sv/ohrb_back.sv
sv/overwriting_history_ring_buffer.sv
test/testbench.sv
